// ===== rtl/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg
// Shared widths, constants and types for the binary to decimal ASCII block.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int VALUE_W     = 63;
    localparam int CHAR_W      = 6;
    localparam int COUNT_W     = 5;
    localparam int MAX_DIGITS  = 19;
    localparam int DIGIT_W     = 4;
    localparam int BCD_W       = MAX_DIGITS * DIGIT_W;
    localparam int BIT_CNT_W   = $clog2(VALUE_W);
    localparam int DIG_IDX_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0]    CHAR_ZERO = CHAR_W'(48);
    localparam logic [DIGIT_W-1:0]   ADJ_LIMIT = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0]   ADJ_ADD   = DIGIT_W'(3);
    localparam logic [BIT_CNT_W-1:0] LAST_BIT  = BIT_CNT_W'(VALUE_W - 1);

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_SCAN,
        BK_EMIT
    } back_state_t;

endpackage

// ===== rtl/bda_in_if.sv =====
// ----------------------------------------------------------------------------
// bda_in_if
// Valid/ready channel carrying one binary value per transaction.
// ----------------------------------------------------------------------------
interface bda_in_if import bda_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

// ===== rtl/bda_out_if.sv =====
// ----------------------------------------------------------------------------
// bda_out_if
// Valid/ready channel carrying one ASCII decimal digit per transaction.
// ----------------------------------------------------------------------------
interface bda_out_if import bda_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  char_code;
    logic               last;
    logic [COUNT_W-1:0] digit_count;

    modport source (output valid, output char_code, output last, output digit_count,
                    input ready);
    modport sink   (input valid, input char_code, input last, input digit_count,
                    output ready);

endinterface

// ===== rtl/bda_queue.sv =====
// ----------------------------------------------------------------------------
// bda_queue
// Front end: accepts values and holds them in a short FIFO for the converter.
// ----------------------------------------------------------------------------
module bda_queue import bda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bda_in_if.sink    in_ch,
    bda_in_if.source  q_ch
);

    logic [VALUE_W-1:0] value_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               push;
    logic               pop;

    assign in_ch.ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_ch.valid  = (cnt_reg != '0);
    assign q_ch.value  = value_mem[rd_ptr_reg];

    assign push = in_ch.valid && in_ch.ready;
    assign pop  = q_ch.valid && q_ch.ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            value_mem[wr_ptr_reg] <= in_ch.value;
        end
    end

endmodule

// ===== rtl/bda_back.sv =====
// ----------------------------------------------------------------------------
// bda_back
// Back end: bit-serial shift-and-add-3 conversion, digit count, then emits
// the digits most significant first through an output register.
// ----------------------------------------------------------------------------
module bda_back import bda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bda_in_if.sink    q_ch,
    bda_out_if.source out_ch
);

    back_state_t          state_reg, state_next;
    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DIG_IDX_W-1:0] dig_idx_reg, dig_idx_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                 out_last_reg, out_last_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;
    logic [BCD_W-1:0]     bcd_adj;
    logic [DIGIT_W-1:0]   cur_digit;
    logic [COUNT_W-1:0]   scan_total;
    logic                 slot_free;

    function automatic logic [BCD_W-1:0] add3_all(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] r;
        r = bcd;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd[i*DIGIT_W +: DIGIT_W] >= ADJ_LIMIT)
            begin
                r[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + ADJ_ADD;
            end
        end
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] digit_total(input logic [BCD_W-1:0] bcd);
        logic [COUNT_W-1:0] n;
        n = COUNT_W'(1);
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd[i*DIGIT_W +: DIGIT_W] != '0)
            begin
                n = COUNT_W'(i + 1);
            end
        end
        return n;
    endfunction

    assign bcd_adj    = add3_all(bcd_reg);
    assign scan_total = digit_total(bcd_reg);
    assign cur_digit  = bcd_reg[{dig_idx_reg, 2'b00} +: DIGIT_W];
    assign slot_free  = !out_valid_reg || out_ch.ready;

    assign q_ch.ready         = (state_reg == BK_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.char_code   = out_char_reg;
    assign out_ch.last        = out_last_reg;
    assign out_ch.digit_count = out_count_reg;

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_idx_next   = dig_idx_reg;
        total_next     = total_reg;
        out_valid_next = out_ch.ready ? 1'b0 : out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_count_next = out_count_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_ch.valid)
                begin
                    bin_next     = q_ch.value;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = BK_CONV;
                end
            end
            BK_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next     = {bin_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == LAST_BIT)
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                total_next   = scan_total;
                dig_idx_next = DIG_IDX_W'(scan_total - COUNT_W'(1));
                state_next   = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + CHAR_W'(cur_digit);
                    out_last_next  = (dig_idx_reg == '0);
                    out_count_next = (dig_idx_reg == '0) ? total_reg : '0;
                    if (dig_idx_reg == '0)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        dig_idx_next = dig_idx_reg - DIG_IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg       <= bin_next;
        bcd_reg       <= bcd_next;
        bit_cnt_reg   <= bit_cnt_next;
        dig_idx_reg   <= dig_idx_next;
        total_reg     <= total_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_count_reg <= out_count_next;
    end

endmodule

// ===== rtl/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts a 63-bit unsigned integer into its decimal ASCII digits.
// ----------------------------------------------------------------------------
// in_ch:  one transaction per value (63 bits, unsigned).
// out_ch: one transaction per digit, most significant first, no leading
//         zeros; zero gives a single '0'. The final digit has last = 1 and
//         digit_count = number of digits (1..19); digit_count is 0 otherwise.
// Values enter a 2-entry queue, so in_ch keeps accepting while the
// converter works on an earlier value.
// Per value the converter loads it, runs one shift-and-add-3 step per
// input bit, counts the digits, then emits the digits one at a time. It
// takes the next value from the queue only after the last digit of the
// current one has gone into the output register.
// A stalled out_ch holds the current digit in the output register and the
// converter waits; once the queue is full in_ch.ready drops.
// Reset (rst_n low, asynchronous) empties the queue and the output register.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii import bda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bda_in_if.sink    in_ch,
    bda_out_if.source out_ch
);

    bda_in_if q_ch ();

    bda_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .q_ch  (q_ch.source)
    );

    bda_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_ch   (q_ch.sink),
        .out_ch (out_ch)
    );

endmodule

// ===== tb/tb_binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii
// Self-checking testbench for the binary to decimal ASCII converter. Values
// are sent on in_ch from a pending queue. Each accepted value is expanded
// into its expected digit transactions. Every digit seen on out_ch is
// compared field by field with the oldest expected one. Directed corner
// values come first, then random values, under changing sender and receiver
// idling. One phase holds the receiver off long enough to fill the block.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii;
    import bda_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES   = 600;
    localparam int TAIL_CYCLES   = 120;
    localparam int DIRECTED_CNT  = 16;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_code;
        logic               last;
        logic [COUNT_W-1:0] digit_count;
    } digit_t;

    logic clk;
    logic rst_n;

    bda_in_if  in_ch();
    bda_out_if out_ch();

    binary_to_decimal_ascii uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    logic [VALUE_W-1:0] pending_values[$];
    digit_t             expected_digits[$];
    int                 error_count        = 0;
    int                 sender_idle_pct    = 0;
    int                 receiver_stall_pct = 0;
    logic               hold_go            = 1'b0;
    logic               hold_active        = 1'b0;

    // expected digit transactions of one value, most significant first
    function automatic void predict_decimal_digits(input logic [VALUE_W-1:0] v);
        logic [63:0]        rest;
        logic [DIGIT_W-1:0] low_first[MAX_DIGITS];
        int                 n;
        digit_t             d;
        rest = {1'b0, v};
        n    = 0;
        do
        begin
            low_first[n] = DIGIT_W'(rest % 64'd10);
            rest         = rest / 64'd10;
            n++;
        end
        while (rest != 64'd0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--)
        begin
            d.char_code   = CHAR_ZERO + CHAR_W'(low_first[k]);
            d.last        = (k == 0);
            d.digit_count = (k == 0) ? COUNT_W'(n) : '0;
            expected_digits.push_back(d);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [63:0] raw;
        int          width;
        raw = {$urandom, $urandom};
        if ($urandom_range(3) == 0)
        begin
            // nineteen-digit band: 10^18 .. 2^63-1
            raw = 64'd1000000000000000000 + (raw % 64'd8223372036854775808);
        end
        else
        begin
            width = $urandom_range(1, VALUE_W);
            raw   = raw & ((64'd1 << width) - 64'd1);
        end
        return raw[VALUE_W-1:0];
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.value <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_decimal_digits(in_ch.value);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_values.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.value <= pending_values.pop_front();
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        digit_t exp_d;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_digits.size() == 0)
                begin
                    $display("%t ERROR unexpected transaction: char %0d last %0b count %0d",
                             $time, out_ch.char_code, out_ch.last, out_ch.digit_count);
                    error_count++;
                end
                else
                begin
                    exp_d = expected_digits.pop_front();
                    if (out_ch.char_code !== exp_d.char_code)
                    begin
                        $display("%t ERROR char_code expected %0d got %0d",
                                 $time, exp_d.char_code, out_ch.char_code);
                        error_count++;
                    end
                    if (out_ch.last !== exp_d.last)
                    begin
                        $display("%t ERROR last expected %0b got %0b",
                                 $time, exp_d.last, out_ch.last);
                        error_count++;
                    end
                    if (out_ch.digit_count !== exp_d.digit_count)
                    begin
                        $display("%t ERROR digit_count expected %0d got %0d",
                                 $time, exp_d.digit_count, out_ch.digit_count);
                        error_count++;
                    end
                end
            end
            out_ch.ready <= !hold_active && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // long receiver hold-off
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    task automatic queue_random(input int n);
        repeat (n) pending_values.push_back(random_value());
    endtask

    task automatic wait_sent();
        while (pending_values.size() != 0)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_values.size() != 0 || in_ch.valid || expected_digits.size() != 0);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
        @(negedge clk);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        queue_random(n);
        wait_sent();
    endtask

    logic [VALUE_W-1:0] directed_values[DIRECTED_CNT] = '{
        63'd0,
        63'd1,
        63'd9,
        63'd10,
        63'd99,
        63'd100,
        63'd12345,
        63'd4294967295,
        63'd999999999999999999,
        63'd1000000000000000000,
        63'd9223372036854775807,
        63'd4611686018427387904,
        63'd6148914691236517205,
        63'd3074457345618258602,
        63'd9000000000000000001,
        63'd5000000000000000000
    };

    initial
    begin
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_values[i])
            pending_values.push_back(directed_values[i]);
        wait_sent();

        run_phase(0, 0, 70);
        run_phase(52, 0, 60);
        run_phase(0, 52, 60);
        run_phase(32, 32, 60);

        // receiver held off while the sender keeps offering
        @(negedge clk);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        queue_random(40);
        hold_go = 1'b1;
        wait_sent();

        // sender pauses until the block has emptied
        wait_drained();
        repeat (20) @(negedge clk);

        run_phase(0, 0, 30);
        run_phase(32, 32, 40);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("Timeout with %0d transactions outstanding", expected_digits.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
